[hw/rtl/wfha_pkg.sv]
// Shared types and codes for the worst-fit heap allocator.
package wfha_pkg;

    localparam int ADDR_W    = 64;
    localparam int SIZE_W    = 32;
    localparam int HDR_W     = 8;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_SIZE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_BYTES = 2'd2;

    typedef enum logic [1:0] {
        ACT_ALLOC  = 2'd0,
        ACT_CALLOC = 2'd1,
        ACT_RESIZE = 2'd2,
        ACT_FREE   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ZERO     = 2'd1,
        ST_NOSPACE  = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    typedef struct packed {
        logic              free;
        logic [SIZE_W-1:0] length;
        logic [SIZE_W-1:0] offset;
    } entry_t;

    typedef struct packed {
        logic    load_in;
        logic    prep;
        logic    scan_clear;
        logic    scan_run;
        logic    write_best;
        logic    write_append;
        logic    write_mark;
        logic    set_copy;
        logic    st_we;
        status_t st_code;
        logic    load_out;
    } dp_cmd_t;

    typedef struct packed {
        action_t act;
        logic    alloc_mode;
        logic    req_zero;
        logic    scan_done;
        logic    best_found;
        logic    match_found;
        logic    append_ok;
    } dp_sts_t;

endpackage

[hw/rtl/wfha_dp.sv]
// Datapath: config registers, block table memory, scan unit and result registers.
module wfha_dp import wfha_pkg::*; #(
    parameter int MAX_BLOCKS = 64,
    localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1,
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_wr_data,
    input  logic [1:0]           s_action,
    input  logic [SIZE_W-1:0]    s_size,
    input  logic [SIZE_W-1:0]    s_count,
    input  logic [ADDR_W-1:0]    s_address,
    input  dp_cmd_t              cmd,
    output dp_sts_t              sts,
    output logic [ADDR_W-1:0]    m_result_address,
    output logic [1:0]           m_status,
    output logic [ADDR_W-1:0]    m_copy_source,
    output logic [SIZE_W-1:0]    m_copy_length
);

    logic [ADDR_W-1:0] heap_base_reg;
    logic [SIZE_W-1:0] heap_size_reg;
    logic [HDR_W-1:0]  header_bytes_reg;

    logic [CNT_W-1:0]  count_reg;
    logic [SIZE_W-1:0] used_reg;

    action_t           action_reg;
    logic [SIZE_W-1:0] size_reg;
    logic [SIZE_W-1:0] count_in_reg;
    logic [ADDR_W-1:0] address_reg;

    logic [SIZE_W-1:0] req_size_reg;
    logic [ADDR_W-1:0] tgt_reg;
    logic [SIZE_W:0]   base_off_reg;

    entry_t            mem [MAX_BLOCKS];
    logic [CNT_W-1:0]  rd_idx_reg;
    logic              rd_pend_reg;
    entry_t            rd_data_reg;
    logic [IDX_W-1:0]  rd_at_reg;

    logic              best_found_reg;
    logic [IDX_W-1:0]  best_idx_reg;
    logic [SIZE_W-1:0] best_len_reg;
    logic [SIZE_W-1:0] best_off_reg;

    logic              match_found_reg;
    logic [IDX_W-1:0]  match_idx_reg;
    logic [SIZE_W-1:0] match_len_reg;
    logic [SIZE_W-1:0] match_off_reg;

    status_t           st_reg;
    logic              res_flag_reg;
    logic [SIZE_W-1:0] res_off_reg;
    logic              copy_flag_reg;

    logic              alloc_mode;
    logic [SIZE_W+1:0] need;
    logic              append_ok;
    logic              issue;
    logic              fit;
    logic              hit;
    logic [SIZE_W-1:0] prod_lo;
    logic [SIZE_W-1:0] copy_len;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_idx;
    entry_t            wr_data;

    assign alloc_mode = (action_reg != ACT_FREE) &&
                        !((action_reg == ACT_RESIZE) && (address_reg != '0));
    assign need       = {1'b0, base_off_reg} + {2'b00, req_size_reg};
    assign append_ok  = (count_reg < CNT_W'(MAX_BLOCKS)) && (need <= {2'b00, heap_size_reg});
    assign issue      = cmd.scan_run && (rd_idx_reg < count_reg);
    assign fit        = rd_pend_reg && alloc_mode && rd_data_reg.free &&
                        (rd_data_reg.length >= req_size_reg) &&
                        (!best_found_reg || (rd_data_reg.length > best_len_reg));
    assign hit        = rd_pend_reg && !alloc_mode && !match_found_reg &&
                        (tgt_reg[ADDR_W-1:SIZE_W] == '0) &&
                        (rd_data_reg.offset == tgt_reg[SIZE_W-1:0]);
    assign prod_lo    = count_in_reg * size_reg;
    assign copy_len   = (match_len_reg < req_size_reg) ? match_len_reg : req_size_reg;

    assign sts.act         = action_reg;
    assign sts.alloc_mode  = alloc_mode;
    assign sts.req_zero    = (req_size_reg == '0);
    assign sts.scan_done   = (rd_idx_reg == count_reg) && !rd_pend_reg;
    assign sts.best_found  = best_found_reg;
    assign sts.match_found = match_found_reg;
    assign sts.append_ok   = append_ok;

    always_comb begin
        wr_en   = 1'b0;
        wr_idx  = best_idx_reg;
        wr_data = '{free: 1'b0, length: best_len_reg, offset: best_off_reg};
        if (cmd.write_best) begin
            wr_en = 1'b1;
        end else if (cmd.write_append) begin
            wr_en   = 1'b1;
            wr_idx  = count_reg[IDX_W-1:0];
            wr_data = '{free: 1'b0, length: req_size_reg, offset: base_off_reg[SIZE_W-1:0]};
        end else if (cmd.write_mark) begin
            wr_en   = 1'b1;
            wr_idx  = match_idx_reg;
            wr_data = '{free: 1'b1, length: match_len_reg, offset: match_off_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_idx] <= wr_data;
        end
        if (issue) begin
            rd_data_reg <= mem[rd_idx_reg[IDX_W-1:0]];
            rd_at_reg   <= rd_idx_reg[IDX_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            heap_base_reg    <= '0;
            heap_size_reg    <= '0;
            header_bytes_reg <= HDR_W'(24);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_HEAP_BASE:    heap_base_reg    <= cfg_wr_data;
                CFG_HEAP_SIZE:    heap_size_reg    <= cfg_wr_data[SIZE_W-1:0];
                CFG_HEADER_BYTES: header_bytes_reg <= cfg_wr_data[HDR_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            used_reg  <= '0;
        end else if (cmd.write_append) begin
            count_reg <= count_reg + CNT_W'(1);
            used_reg  <= need[SIZE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            action_reg   <= action_t'(s_action);
            size_reg     <= s_size;
            count_in_reg <= s_count;
            address_reg  <= s_address;
        end
        if (cmd.prep) begin
            req_size_reg <= (action_reg == ACT_CALLOC) ? prod_lo : size_reg;
            tgt_reg      <= address_reg - heap_base_reg;
            base_off_reg <= {1'b0, used_reg} + (SIZE_W+1)'(header_bytes_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_idx_reg      <= '0;
            rd_pend_reg     <= 1'b0;
            best_found_reg  <= 1'b0;
            match_found_reg <= 1'b0;
        end else if (cmd.scan_clear) begin
            rd_idx_reg      <= '0;
            rd_pend_reg     <= 1'b0;
            best_found_reg  <= 1'b0;
            match_found_reg <= 1'b0;
        end else begin
            rd_pend_reg <= issue;
            if (issue) begin
                rd_idx_reg <= rd_idx_reg + CNT_W'(1);
            end
            if (fit) begin
                best_found_reg <= 1'b1;
            end
            if (hit) begin
                match_found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fit) begin
            best_idx_reg <= rd_at_reg;
            best_len_reg <= rd_data_reg.length;
            best_off_reg <= rd_data_reg.offset;
        end
        if (hit) begin
            match_idx_reg <= rd_at_reg;
            match_len_reg <= rd_data_reg.length;
            match_off_reg <= rd_data_reg.offset;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg        <= ST_OK;
            res_flag_reg  <= 1'b0;
            copy_flag_reg <= 1'b0;
        end else if (cmd.load_in) begin
            st_reg        <= ST_OK;
            res_flag_reg  <= 1'b0;
            copy_flag_reg <= 1'b0;
        end else begin
            if (cmd.st_we) begin
                st_reg <= cmd.st_code;
            end
            if (cmd.write_best || cmd.write_append) begin
                res_flag_reg <= 1'b1;
            end
            if (cmd.set_copy) begin
                copy_flag_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.write_best) begin
            res_off_reg <= best_off_reg;
        end else if (cmd.write_append) begin
            res_off_reg <= base_off_reg[SIZE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_status         <= st_reg;
            m_result_address <= ((st_reg == ST_OK) && res_flag_reg) ?
                                heap_base_reg + ADDR_W'(res_off_reg) : '0;
            m_copy_source    <= ((st_reg == ST_OK) && copy_flag_reg) ? address_reg : '0;
            m_copy_length    <= ((st_reg == ST_OK) && copy_flag_reg) ? copy_len : '0;
        end
    end

endmodule

[hw/rtl/wfha_ctrl.sv]
// Controller: request sequencing state machine and handshakes.
module wfha_ctrl import wfha_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    output logic    m_valid,
    input  logic    m_ready,
    input  dp_sts_t sts,
    output dp_cmd_t cmd
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_PREP   = 7'b0000010,
        S_CHECK  = 7'b0000100,
        S_SCAN   = 7'b0001000,
        S_DECIDE = 7'b0010000,
        S_MARK   = 7'b0100000,
        S_FINISH = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;
    logic   out_free;

    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.st_code  = ST_OK;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = S_PREP;
                end
            end
            S_PREP: begin
                cmd.prep   = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK: begin
                if ((sts.act != ACT_FREE) && sts.req_zero) begin
                    cmd.st_we   = 1'b1;
                    cmd.st_code = ST_ZERO;
                    state_next  = S_FINISH;
                end else begin
                    cmd.scan_clear = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN: begin
                cmd.scan_run = 1'b1;
                if (sts.scan_done) begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                state_next = S_FINISH;
                if (sts.alloc_mode) begin
                    if (sts.best_found) begin
                        cmd.write_best = 1'b1;
                    end else if (sts.append_ok) begin
                        cmd.write_append = 1'b1;
                    end else begin
                        cmd.st_we   = 1'b1;
                        cmd.st_code = ST_NOSPACE;
                    end
                end else if (sts.act == ACT_FREE) begin
                    if (sts.match_found) begin
                        cmd.write_mark = 1'b1;
                    end else begin
                        cmd.st_we   = 1'b1;
                        cmd.st_code = ST_NOTFOUND;
                    end
                end else if (!sts.match_found) begin
                    cmd.st_we   = 1'b1;
                    cmd.st_code = ST_NOTFOUND;
                end else if (!sts.append_ok) begin
                    cmd.st_we   = 1'b1;
                    cmd.st_code = ST_NOSPACE;
                end else begin
                    cmd.write_append = 1'b1;
                    cmd.set_copy     = 1'b1;
                    state_next       = S_MARK;
                end
            end
            S_MARK: begin
                cmd.write_mark = 1'b1;
                state_next     = S_FINISH;
            end
            S_FINISH: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

[hw/rtl/worst_fit_heap_allocator.sv]
// Top level of the worst-fit heap allocator.
//
// Requests arrive as one beat on the s_ channel (action, size, count, address)
// and each produces exactly one result beat on the m_ channel (result_address,
// status, copy_source, copy_length). Both use valid/ready.
// Configuration (heap_base, heap_size, header_bytes) is written through
// cfg_wr_en/cfg_index/cfg_wr_data, by the user only while no request is in
// flight; the block itself leaves this to the user. A request steps through
// S_PREP, S_CHECK, S_SCAN, S_DECIDE and S_FINISH after it is accepted. The
// scan reads the N blocks in the table, one entry per cycle, as the block
// table memory has one read port. A resize that succeeds adds the S_MARK
// state for the second table write; a zero-size alloc, calloc or resize
// request skips the scan. One request is in flight at a time.
// The result sits in an output register: a new request is accepted while the
// previous result waits, but the next result holds in the controller until
// m_ready frees the register.
// Reset (aresetn, synchronous, active low) empties the table, zeroes the bump
// pointer and returns the registers to heap_base 0, heap_size 0, header 24.
module worst_fit_heap_allocator import wfha_pkg::*; #(
    parameter int MAX_BLOCKS = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_wr_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_action,
    input  logic [SIZE_W-1:0]    s_size,
    input  logic [SIZE_W-1:0]    s_count,
    input  logic [ADDR_W-1:0]    s_address,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [ADDR_W-1:0]    m_result_address,
    output logic [1:0]           m_status,
    output logic [ADDR_W-1:0]    m_copy_source,
    output logic [SIZE_W-1:0]    m_copy_length
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    wfha_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    wfha_dp #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wr_data      (cfg_wr_data),
        .s_action         (s_action),
        .s_size           (s_size),
        .s_count          (s_count),
        .s_address        (s_address),
        .cmd              (cmd),
        .sts              (sts),
        .m_result_address (m_result_address),
        .m_status         (m_status),
        .m_copy_source    (m_copy_source),
        .m_copy_length    (m_copy_length)
    );

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request accepted while another is in flight");

    a_fail_clears_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status != ST_OK)) |->
            ((m_result_address == '0) && (m_copy_source == '0) && (m_copy_length == '0)))
        else $error("failed result carries nonzero fields");

    a_copy_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_copy_source != '0)) |->
            ((m_status == ST_OK) && (m_copy_length != '0)))
        else $error("copy source without successful copy length");

    a_single_cmd_write: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.write_best, cmd.write_append, cmd.write_mark}))
        else $error("more than one table write in a cycle");

endmodule
